>>> src/fts_pkg.sv
// Package for the frame time statistics unit: payload structs, constants,
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package fts_pkg;
	localparam int DEPTH = 256;
	localparam int AW = 8;
	localparam int KMAX = 3;
	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUM = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam logic [21:0] MAX_FRAME = 22'd2560000;
	localparam logic [37:0] MISS_LIMIT = 38'd384000;
	localparam logic [27:0] RATE_SCALE = 28'd65536000;

	typedef struct packed {
		logic [1:0] func;
		logic [21:0] frame_time;
		logic [7:0] entry_index;
	} in_word_t;

	typedef struct packed {
		logic [21:0] entry_frame;
		logic [8:0] sample_count;
		logic [21:0] current_frame;
		logic [21:0] average_frame;
		logic [21:0] worst_frame;
		logic [8:0] missed_count;
		logic [25:0] low_rate;
	} out_word_t;

	typedef struct packed {
		logic start_sum;
		logic start_read;
		logic do_add;
	} cmd_t;

	typedef struct packed {
		logic done;
	} stat_t;
endpackage
`default_nettype wire

>>> src/fts_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module fts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> src/fts_datapath.sv
// Datapath: window memory, pointers, scan accumulators, top-three tracker and
// a restoring divider. Depends on fts_pkg and fts_ram.
`default_nettype none
module fts_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire fts_pkg::cmd_t cmd,
	input wire fts_pkg::in_word_t in_word,
	input wire logic [15:0] target_rate,
	output fts_pkg::stat_t stat,
	output fts_pkg::out_word_t out_word
);
	localparam logic [2:0] P_IDLE = 3'd0, P_SCAN = 3'd1, P_DIV = 3'd2, P_RD = 3'd3,
		P_FIN = 3'd4;
	logic [2:0] ph_q;
	logic [7:0] wp_q;
	logic [8:0] cnt_q;
	logic [8:0] issue_q, recv_q;
	logic idx_ok_q;
	logic [7:0] raddr;
	logic [22:0] rdata;
	logic [29:0] total_q;
	logic [21:0] worst_q, cur_q, t0_q, t1_q, t2_q;
	logic [8:0] miss_q;
	logic [1:0] k_q;
	logic [27:0] num_q;
	logic [23:0] den_q;
	logic [24:0] rem_q;
	logic [4:0] bit_q;
	logic [25:0] quo_q;
	logic [29:0] avg_rem_q;
	logic [21:0] avg_q;
	logic [21:0] entry_q;
	logic done_q;
	logic we;
	logic miss_bit;
	logic [37:0] prod;
	logic [7:0] oldest;
	logic [21:0] f;
	logic [24:0] trial;
	logic [29:0] atrial;

	function automatic logic [27:0] RATE_SCALE_K(input logic [1:0] k);
		RATE_SCALE_K = (k == 2'd3) ? 28'd196608000 : (k == 2'd2) ? 28'd131072000 :
			fts_pkg::RATE_SCALE;
	endfunction

	assign prod = 38'(in_word.frame_time) * 38'(target_rate);
	assign miss_bit = (target_rate != 16'd0) && (prod > fts_pkg::MISS_LIMIT);
	assign we = cmd.do_add && in_word.frame_time != 22'd0 &&
		in_word.frame_time <= fts_pkg::MAX_FRAME;
	assign oldest = cnt_q[8] ? wp_q : 8'd0;
	// a summary starts its walk at the oldest entry, a read at the requested age
	assign raddr = (ph_q == P_IDLE) ?
		oldest + (cmd.start_read ? in_word.entry_index : 8'd0) : oldest + issue_q[7:0];
	assign f = rdata[21:0];

	fts_ram #(.WIDTH(23), .DEPTH(fts_pkg::DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(wp_q), .wdata({miss_bit, in_word.frame_time}),
		.raddr(raddr), .rdata(rdata)
	);

	assign trial = {rem_q[23:0], num_q[27]} - {1'b0, den_q};
	assign atrial = {avg_rem_q[28:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_IDLE;
			wp_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (we) begin
				wp_q <= wp_q + 8'd1;
				if (!cnt_q[8]) cnt_q <= cnt_q + 9'd1;
			end
			case (ph_q)
				P_IDLE: begin
					if (cmd.start_read) begin
						idx_ok_q <= ({1'b0, in_word.entry_index} < cnt_q);
						ph_q <= P_RD;
					end else if (cmd.start_sum) begin
						if (cnt_q == 9'd0) begin
							ph_q <= P_FIN;
						end else begin
							ph_q <= P_SCAN;
							issue_q <= 9'd1;
							recv_q <= '0;
						end
						total_q <= '0; worst_q <= '0; miss_q <= '0;
						t0_q <= '0; t1_q <= '0; t2_q <= '0;
						k_q <= (cnt_q > 9'd200) ? 2'd3 : (cnt_q > 9'd100) ? 2'd2 : 2'd1;
					end
				end
				P_RD: begin
					entry_q <= idx_ok_q ? f : '0;
					ph_q <= P_FIN;
				end
				P_SCAN: begin
					// the RAM read issued last cycle is in rdata now
					total_q <= total_q + 30'(f);
					if (f > worst_q) worst_q <= f;
					if (rdata[22]) miss_q <= miss_q + 9'd1;
					if (f > t0_q) begin
						t0_q <= f; t1_q <= t0_q; t2_q <= t1_q;
					end else if (f > t1_q) begin
						t1_q <= f; t2_q <= t1_q;
					end else if (f > t2_q) t2_q <= f;
					cur_q <= f;
					issue_q <= issue_q + 9'd1;
					recv_q <= recv_q + 9'd1;
					if (recv_q + 9'd1 == cnt_q) begin
						ph_q <= P_DIV;
						bit_q <= 5'd0;
					end
				end
				P_DIV: begin
					if (bit_q == 5'd0) begin
						den_q <= 24'(t0_q) + ((k_q > 2'd1) ? 24'(t1_q) : 24'd0) +
							((k_q > 2'd2) ? 24'(t2_q) : 24'd0);
						num_q <= RATE_SCALE_K(k_q);
						rem_q <= '0; quo_q <= '0;
						// the mean fits in 22 bits, so the bits above 21 start the remainder
						avg_rem_q <= {22'd0, total_q[29:22]};
						avg_q <= '0;
						bit_q <= 5'd1;
					end else begin
						rem_q <= trial[24] ? {rem_q[23:0], num_q[27]} : trial;
						num_q <= {num_q[26:0], 1'b0};
						quo_q <= {quo_q[24:0], ~trial[24]};
						if (bit_q > 5'd6) begin
							if (atrial[29:0] + 30'(total_q[5'd28 - bit_q]) >= 30'(cnt_q)) begin
								avg_rem_q <= atrial + 30'(total_q[5'd28 - bit_q]) - 30'(cnt_q);
								avg_q <= {avg_q[20:0], 1'b1};
							end else begin
								avg_rem_q <= atrial + 30'(total_q[5'd28 - bit_q]);
								avg_q <= {avg_q[20:0], 1'b0};
							end
						end
						bit_q <= bit_q + 5'd1;
						if (bit_q == 5'd28) ph_q <= P_FIN;
					end
				end
				P_FIN: begin
					done_q <= 1'b1;
					ph_q <= P_IDLE;
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	logic rd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_q <= 1'b0;
		else if (ph_q == P_IDLE && (cmd.start_read || cmd.start_sum)) rd_q <= cmd.start_read;
	end

	assign stat.done = done_q;

	always_comb begin
		out_word = '0;
		out_word.sample_count = cnt_q;
		if (rd_q) out_word.entry_frame = entry_q;
		else if (cnt_q != 9'd0) begin
			out_word.current_frame = cur_q;
			out_word.average_frame = avg_q;
			out_word.worst_frame = worst_q;
			out_word.missed_count = miss_q;
			out_word.low_rate = quo_q;
		end
	end
endmodule
`default_nettype wire

>>> src/fts_ctrl.sv
// Controller: handshake, command issue and output valid state.
// Depends on fts_pkg.
`default_nettype none
module fts_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire fts_pkg::in_word_t in_word,
	output logic out_valid,
	input wire logic out_stall,
	output fts_pkg::cmd_t cmd,
	input wire fts_pkg::stat_t stat
);
	localparam logic [1:0] S_IDLE = 2'd0, S_WORK = 2'd1, S_OUT = 2'd2;
	logic [1:0] st_q;
	logic acc;
	assign in_stall = (st_q != S_IDLE);
	assign acc = in_valid && !in_stall;
	assign cmd.do_add = acc && in_word.func == fts_pkg::FUNC_ADD;
	assign cmd.start_sum = acc && in_word.func == fts_pkg::FUNC_SUM;
	assign cmd.start_read = acc && in_word.func == fts_pkg::FUNC_READ;
	assign out_valid = (st_q == S_OUT);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else begin
			case (st_q)
				S_IDLE: if (cmd.start_sum || cmd.start_read) st_q <= S_WORK;
				S_WORK: if (stat.done) st_q <= S_OUT;
				S_OUT: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> src/frame_time_statistics_unit.sv
// Top level of the frame time statistics unit: controller plus datapath.
// Depends on fts_pkg, fts_ctrl, fts_datapath, fts_ram.
//
// Usage: input words (func, frame_time, entry_index) enter on in_valid/in_stall;
// result words leave on out_valid/out_stall. An add word stores a frame and
// yields no result. A read word passes through the read and finish states
// before out_valid rises. A summary word walks every stored frame through the RAM
// read port, one per cycle, then runs a 28-step shift-subtract divide for the
// low rate alongside the average before out_valid rises.
// One word is in work at a time; in_stall stays high until its result is taken.
// If the receiver stalls, the result word holds and input stays stalled.
// Reset clears the window (count and write pointer) and target_rate; the RAM
// contents need no clearing since only written entries are ever used.
// The user must write target_rate through cfg_we/cfg_data only while the unit
// is idle; the unit itself does not enforce this.
`default_nettype none
module frame_time_statistics_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire fts_pkg::in_word_t in_word,
	output logic out_valid,
	input wire logic out_stall,
	output fts_pkg::out_word_t out_word,
	input wire logic cfg_we,
	input wire logic [15:0] cfg_data
);
	fts_pkg::cmd_t cmd;
	fts_pkg::stat_t stat;
	logic [15:0] target_rate_q;

	// hold the target rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) target_rate_q <= '0;
		else if (cfg_we) target_rate_q <= cfg_data;
	end

	fts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .stat(stat)
	);

	fts_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_word(in_word),
		.target_rate(target_rate_q), .stat(stat), .out_word(out_word)
	);
endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Testbench for frame_time_statistics_unit: drives add, summary, read and no-op words
// and checks every result word against an in-bench window model.
// Depends on fts_pkg and the frame_time_statistics_unit RTL.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fts_pkg::*;

	localparam int CYCLE_LIMIT = 900000;
	localparam int SETTLE = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	logic in_taken = 1'b0;

	frame_time_statistics_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Window model: frames, miss flags, write pointer, fill count, target rate.
	logic [21:0] win_frame [DEPTH];
	logic win_miss [DEPTH];
	int unsigned win_wp;
	int unsigned win_fill;
	logic [15:0] win_rate;

	in_word_t pending_words [$];
	out_word_t expected_results [$];
	int unsigned mismatches;
	int unsigned cycles;
	int send_idle_pct;
	int stall_pct;
	int hold_off;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned slot_at_age(int unsigned age);
		return ((win_fill == DEPTH ? win_wp : 0) + age) % DEPTH;
	endfunction

	// Apply an accepted word to the model, queue the result it causes.
	function automatic void predict_word(in_word_t w);
		out_word_t r;
		logic [63:0] total, slowest, prod;
		logic [21:0] f, worst;
		logic [21:0] top [KMAX];
		int unsigned missed, k, s;
		r = '0;
		total = 0;
		slowest = 0;
		worst = 0;
		missed = 0;
		case (w.func)
			FUNC_ADD: begin
				if (w.frame_time != 0 && w.frame_time <= MAX_FRAME) begin
					prod = 64'(w.frame_time) * 64'(win_rate);
					win_frame[win_wp] = w.frame_time;
					win_miss[win_wp] = win_rate != 0 && prod > 64'(MISS_LIMIT);
					win_wp = (win_wp + 1) % DEPTH;
					if (win_fill < DEPTH) win_fill++;
				end
			end
			FUNC_SUM: begin
				r.sample_count = 9'(win_fill);
				if (win_fill != 0) begin
					foreach (top[j]) top[j] = '0;
					for (int unsigned i = 0; i < win_fill; i++) begin
						s = slot_at_age(i);
						f = win_frame[s];
						total += f;
						if (f > worst) worst = f;
						if (win_miss[s]) missed++;
						// keep the KMAX largest in descending order
						for (int j = 0; j < KMAX; j++) begin
							if (f > top[j]) begin
								for (int m = KMAX - 1; m > j; m--) top[m] = top[m - 1];
								top[j] = f;
								break;
							end
						end
					end
					k = (win_fill + 99) / 100;
					for (int j = 0; j < k; j++) slowest += top[j];
					r.current_frame = win_frame[slot_at_age(win_fill - 1)];
					r.average_frame = 22'(total / win_fill);
					r.worst_frame = worst;
					r.missed_count = 9'(missed);
					r.low_rate = 26'((64'(RATE_SCALE) * k) / slowest);
				end
				expected_results.push_back(r);
			end
			FUNC_READ: begin
				r.sample_count = 9'(win_fill);
				if (w.entry_index < win_fill)
					r.entry_frame = win_frame[slot_at_age(w.entry_index)];
				expected_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// Record acceptance at the rising edge, where the handshake is decided.
	always @(posedge clk) in_taken <= arst_n && in_valid && !in_stall;

	// Driver: hold the word while stalled, advance on acceptance.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				predict_word(in_word);
				void'(pending_words.pop_front());
			end
			if (pending_words.size() != 0 &&
					(in_valid && !in_taken || $urandom_range(99) >= send_idle_pct)) begin
				in_valid <= 1'b1;
				in_word <= pending_words[0];
			end else begin
				in_valid <= 1'b0;
			end
			out_stall <= hold_off > 0 || $urandom_range(99) < stall_pct;
		end
	end

	// Long hold-off counted in its own process.
	always @(posedge clk) if (hold_off > 0) hold_off <= hold_off - 1;

	// Monitor: compare each result word with the oldest expectation.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				out_word_t e;
				e = expected_results.pop_front();
				if (out_word.entry_frame !== e.entry_frame)
					report_mismatch("entry_frame", out_word.entry_frame, e.entry_frame);
				if (out_word.sample_count !== e.sample_count)
					report_mismatch("sample_count", out_word.sample_count, e.sample_count);
				if (out_word.current_frame !== e.current_frame)
					report_mismatch("current_frame", out_word.current_frame, e.current_frame);
				if (out_word.average_frame !== e.average_frame)
					report_mismatch("average_frame", out_word.average_frame, e.average_frame);
				if (out_word.worst_frame !== e.worst_frame)
					report_mismatch("worst_frame", out_word.worst_frame, e.worst_frame);
				if (out_word.missed_count !== e.missed_count)
					report_mismatch("missed_count", out_word.missed_count, e.missed_count);
				if (out_word.low_rate !== e.low_rate)
					report_mismatch("low_rate", out_word.low_rate, e.low_rate);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("frame_time_statistics_unit test failed");
			$finish;
		end
	end

	function automatic in_word_t make_word(logic [1:0] fn, logic [21:0] ft, logic [7:0] idx);
		in_word_t w;
		w.func = fn;
		w.frame_time = ft;
		w.entry_index = idx;
		return w;
	endfunction

	// Frame times: mostly valid, some oversized to exercise discard, some tiny or MAX_FRAME.
	function automatic logic [21:0] rand_frame();
		case ($urandom_range(9))
			0: return 22'($urandom);
			1: return 22'(MAX_FRAME) + 22'($urandom_range(1, 3));
			2: return 22'($urandom_range(1, 3));
			3: return MAX_FRAME;
			default: return 22'($urandom_range(2000, 12000));
		endcase
	endfunction

	function automatic in_word_t rand_word();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 60) return make_word(FUNC_ADD, rand_frame(), 8'($urandom));
		if (p < 75) return make_word(FUNC_SUM, 22'($urandom), 8'($urandom));
		if (p < 97) return make_word(FUNC_READ, 22'($urandom), 8'($urandom));
		return make_word(FUNC_NOP, 22'($urandom), 8'($urandom));
	endfunction

	// Drain everything, then let a trailing word settle before a register write.
	task automatic drain();
		while (pending_words.size() != 0 || expected_results.size() != 0 || in_valid)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_rate(logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		win_rate = v;
	endtask

	task automatic run_phase(int idle, int stall, int n, logic [15:0] rate);
		drain();
		write_rate(rate);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (n) pending_words.push_back(rand_word());
	endtask

	initial begin
		mismatches = 0;
		cycles = 0;
		win_wp = 0;
		win_fill = 0;
		win_rate = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off = 0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: empty window, discards, extremes, every func code.
		pending_words.push_back(make_word(FUNC_SUM, '0, '0));
		pending_words.push_back(make_word(FUNC_READ, '0, '0));
		pending_words.push_back(make_word(FUNC_ADD, '0, '0));
		pending_words.push_back(make_word(FUNC_ADD, 22'(MAX_FRAME) + 22'd1, '0));
		pending_words.push_back(make_word(FUNC_ADD, '1, '1));
		pending_words.push_back(make_word(FUNC_SUM, '1, '1));
		pending_words.push_back(make_word(FUNC_ADD, 22'd1, '0));
		pending_words.push_back(make_word(FUNC_ADD, MAX_FRAME, '0));
		pending_words.push_back(make_word(FUNC_ADD, 22'd4266, '0));
		pending_words.push_back(make_word(FUNC_NOP, '1, '1));
		pending_words.push_back(make_word(FUNC_SUM, '0, '0));
		pending_words.push_back(make_word(FUNC_READ, '0, 8'd0));
		pending_words.push_back(make_word(FUNC_READ, '0, 8'd2));
		pending_words.push_back(make_word(FUNC_READ, '0, 8'd3));
		pending_words.push_back(make_word(FUNC_READ, '0, '1));
		drain();
		// Rate 90: 4266*90 = 383940 stays on target, 4267*90 misses.
		write_rate(16'd90);
		pending_words.push_back(make_word(FUNC_ADD, 22'd4266, '0));
		pending_words.push_back(make_word(FUNC_ADD, 22'd4267, '0));
		pending_words.push_back(make_word(FUNC_SUM, '0, '0));

		// Random phases: no idling, sender idle, receiver stall, both.
		run_phase(0, 0, 140, 16'd60);
		run_phase(50, 0, 140, 16'hFFFF);
		run_phase(0, 50, 140, 16'd0);
		run_phase(8, 8, 140, 16'd144);

		// Long receiver hold-off while the sender keeps offering words.
		drain();
		hold_off = 2000;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (20) pending_words.push_back(make_word(FUNC_SUM, '0, '0));

		drain();
		if (mismatches == 0) begin
			$display("frame_time_statistics_unit test passed");
		end else begin
			$display("frame_time_statistics_unit test failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> frame_time_statistics_unit.f
src/fts_pkg.sv
src/fts_ram.sv
src/fts_datapath.sv
src/fts_ctrl.sv
src/frame_time_statistics_unit.sv
verif/tb_top.sv
